/* rtl/mgt_pkg.sv */
// Shared types, constants and helper functions of the Markov gate transition unit.
`timescale 1ns / 1ps

package mgt_pkg;

  localparam int unsigned NodeCountDefault = 8;

  localparam int unsigned OpW     = 1;
  localparam int unsigned RowW    = 4;
  localparam int unsigned ColW    = 4;
  localparam int unsigned ValW    = 8;
  localparam int unsigned NodeW   = 8;
  localparam int unsigned DrawW   = 31;
  localparam int unsigned SumW    = 12;
  localparam int unsigned CntW    = 3;
  localparam int unsigned ListW   = 12;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned AddrW   = RowW + ColW;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 12;

  localparam logic [SumW-1:0] SumMax = '1;

  typedef enum logic [OpW-1:0] {
    OpLoad   = 1'b0,
    OpUpdate = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNumInputs    = 3'd0,
    CfgNumOutputs   = 3'd1,
    CfgInputNodes   = 3'd2,
    CfgOutputNodes  = 3'd3,
    CfgDeterministic = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [ValW-1:0] max_value;
    logic [ColW-1:0] max_column;
  } row_stats_t;

  typedef struct packed {
    logic            en;
    logic [RowW-1:0] row;
    row_stats_t      data;
  } stats_wr_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [ValW-1:0]  data;
  } tbl_wr_t;

  // Node counts outside 1..4 are pulled back into range.
  function automatic logic [CntW-1:0] clamp_count(input logic [CntW-1:0] n);
    logic [CntW-1:0] res;
    res = n;
    if (n < 3'd1) res = 3'd1;
    if (n > 3'd4) res = 3'd4;
    return res;
  endfunction

  function automatic logic [SlotW-1:0] node_at(input logic [ListW-1:0] nodes,
                                               input logic [1:0]       slot,
                                               input logic [SlotW-1:0] node_mask);
    return nodes[3*slot +: SlotW] & node_mask;
  endfunction

  // The first input node lands in the highest used bit of the row index.
  function automatic logic [RowW-1:0] gather_row(input logic [NodeW-1:0] states,
                                                 input logic [ListW-1:0] nodes,
                                                 input logic [CntW-1:0]  count,
                                                 input logic [SlotW-1:0] node_mask);
    logic [RowW-1:0] idx;
    idx = '0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < count) begin
        idx = {idx[RowW-2:0], states[node_at(nodes, 2'(i), node_mask)]};
      end
    end
    return idx;
  endfunction

  function automatic logic [NodeW-1:0] scatter_mask(input logic [ColW-1:0]  col,
                                                    input logic [ListW-1:0] nodes,
                                                    input logic [CntW-1:0]  count,
                                                    input logic [SlotW-1:0] node_mask);
    logic [NodeW-1:0] mask;
    mask = '0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < count) begin
        mask[node_at(nodes, 2'(i), node_mask)] = mask[node_at(nodes, 2'(i), node_mask)] |
                                                 col[i];
      end
    end
    return mask;
  endfunction

endpackage

/* rtl/mgt_ifs.sv */
// Handshake channel interfaces of the Markov gate transition unit.
`timescale 1ns / 1ps

interface mgt_in_if;
  logic                       valid;
  logic                       ready;
  logic [mgt_pkg::OpW-1:0]    operation;
  logic [mgt_pkg::RowW-1:0]   row;
  logic [mgt_pkg::ColW-1:0]   column;
  logic [mgt_pkg::ValW-1:0]   entry_value;
  logic [mgt_pkg::NodeW-1:0]  node_states;
  logic [mgt_pkg::DrawW-1:0]  random_draw;

  modport source (output valid, operation, row, column, entry_value, node_states,
                  random_draw, input ready);
  modport sink (input valid, operation, row, column, entry_value, node_states,
                random_draw, output ready);
endinterface

interface mgt_out_if;
  logic                      valid;
  logic                      ready;
  logic [mgt_pkg::NodeW-1:0] or_mask;
  logic [mgt_pkg::ColW-1:0]  chosen_column;

  modport source (output valid, or_mask, chosen_column, input ready);
  modport sink (input valid, or_mask, chosen_column, output ready);
endinterface

interface mgt_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mgt_pkg::CfgIdxW-1:0] index;
  logic [mgt_pkg::CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/markov_gate_transition_unit.sv */
// Markov gate transition unit: table load with running row statistics and gate update.
//
// One transaction is handled at a time. In a load the row statistics are read, then the
// table byte and the updated sum and argmax are written back. A deterministic update goes
// from the statistics read to the finish state, which fills the result register. A
// stochastic update with a row sum above one walks k table columns, k from 1 to 16, after
// the remainder of the random draw is worked out one bit per cycle; the walk reads one
// table byte per cycle from the single read port of the table memory. With a row sum of
// zero or one the remainder step is skipped. A finished result waits in the output
// register while the next input is taken in; an update only stalls at its end if the
// previous result is still held.
`timescale 1ns / 1ps

module markov_gate_transition_unit #(
  parameter int unsigned NodeCount = mgt_pkg::NodeCountDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mgt_in_if.sink     in_i,
  mgt_out_if.source  out_o,
  mgt_cfg_if.sink    cfg_i
);

  localparam logic [mgt_pkg::SlotW-1:0] NodeMask = mgt_pkg::SlotW'((NodeCount - 1) & 7);

  typedef enum logic [2:0] {
    StIdle,
    StLoadWb,
    StUpdStats,
    StDiv,
    StWalkStart,
    StWalk,
    StFinish
  } state_e;

  // Configuration registers.
  logic [mgt_pkg::CntW-1:0]  num_inputs_q;
  logic [mgt_pkg::CntW-1:0]  num_outputs_q;
  logic [mgt_pkg::ListW-1:0] input_nodes_q;
  logic [mgt_pkg::ListW-1:0] output_nodes_q;
  logic                      deterministic_q;

  state_e                    state_q, state_d;
  logic [mgt_pkg::RowW-1:0]  row_q, row_d;
  logic [mgt_pkg::ColW-1:0]  col_q, col_d;
  logic [mgt_pkg::ValW-1:0]  val_q, val_d;
  logic [mgt_pkg::DrawW-1:0] draw_q, draw_d;
  logic [mgt_pkg::SumW-1:0]  rem_left_q, rem_left_d;
  logic                      out_valid_q, out_valid_d;
  logic [mgt_pkg::NodeW-1:0] or_mask_q, or_mask_d;
  logic [mgt_pkg::ColW-1:0]  chosen_q, chosen_d;

  logic [mgt_pkg::CntW-1:0]  n_in;
  logic [mgt_pkg::CntW-1:0]  n_out;
  logic [mgt_pkg::ColW-1:0]  last_col;
  logic [mgt_pkg::RowW-1:0]  upd_row;
  logic                      in_accept;

  logic [mgt_pkg::RowW-1:0]  stats_rd_row;
  mgt_pkg::row_stats_t       stats_rd;
  mgt_pkg::stats_wr_t        stats_wr;
  logic [mgt_pkg::AddrW-1:0] tbl_rd_addr;
  logic [mgt_pkg::ValW-1:0]  tbl_rd;
  mgt_pkg::tbl_wr_t          tbl_wr;

  logic                      mod_start;
  logic                      mod_done;
  logic [mgt_pkg::SumW-1:0]  mod_rem;

  logic [mgt_pkg::ValW-1:0]  stored;
  logic [mgt_pkg::SumW:0]    sum_ext;

  assign n_in      = mgt_pkg::clamp_count(num_inputs_q);
  assign n_out     = mgt_pkg::clamp_count(num_outputs_q);
  assign last_col  = mgt_pkg::ColW'((5'd1 << n_out) - 5'd1);
  assign upd_row   = mgt_pkg::gather_row(in_i.node_states, input_nodes_q, n_in, NodeMask);
  assign in_i.ready = (state_q == StIdle);
  assign in_accept = in_i.valid && in_i.ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_inputs_q    <= 3'd1;
      num_outputs_q   <= 3'd1;
      input_nodes_q   <= '0;
      output_nodes_q  <= '0;
      deterministic_q <= 1'b1;
    end else if (cfg_i.valid) begin
      case (mgt_pkg::cfg_reg_e'(cfg_i.index))
        mgt_pkg::CfgNumInputs:     num_inputs_q    <= cfg_i.data[mgt_pkg::CntW-1:0];
        mgt_pkg::CfgNumOutputs:    num_outputs_q   <= cfg_i.data[mgt_pkg::CntW-1:0];
        mgt_pkg::CfgInputNodes:    input_nodes_q   <= cfg_i.data;
        mgt_pkg::CfgOutputNodes:   output_nodes_q  <= cfg_i.data;
        mgt_pkg::CfgDeterministic: deterministic_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // In stochastic mode a zero byte is stored as one.
  assign stored  = (!deterministic_q && (val_q == '0)) ? 8'd1 : val_q;
  assign sum_ext = {1'b0, stats_rd.sum} + {5'd0, stored};

  always_comb begin
    stats_rd_row = row_q;
    if (state_q == StIdle) begin
      stats_rd_row = (mgt_pkg::op_e'(in_i.operation) == mgt_pkg::OpLoad) ? in_i.row : upd_row;
    end
  end

  always_comb begin
    stats_wr.en              = (state_q == StLoadWb);
    stats_wr.row             = row_q;
    stats_wr.data.sum        = sum_ext[mgt_pkg::SumW] ? mgt_pkg::SumMax
                                                      : sum_ext[mgt_pkg::SumW-1:0];
    stats_wr.data.max_value  = stats_rd.max_value;
    stats_wr.data.max_column = stats_rd.max_column;
    if (val_q > stats_rd.max_value) begin
      stats_wr.data.max_value  = val_q;
      stats_wr.data.max_column = col_q;
    end
    tbl_wr.en   = (state_q == StLoadWb);
    tbl_wr.addr = {row_q, col_q};
    tbl_wr.data = stored;
  end

  // During the walk the byte of the following column is fetched ahead.
  assign tbl_rd_addr = (state_q == StWalk) ? {row_q, col_q + 4'd1} : {row_q, 4'd0};

  assign mod_start = (state_q == StUpdStats) && !deterministic_q && (stats_rd.sum > 12'd1);

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    val_d       = val_q;
    draw_d      = draw_q;
    rem_left_d  = rem_left_q;
    out_valid_d = out_valid_q;
    or_mask_d   = or_mask_q;
    chosen_d    = chosen_q;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_accept) begin
          row_d  = stats_rd_row;
          col_d  = in_i.column;
          val_d  = in_i.entry_value;
          draw_d = in_i.random_draw;
          if (mgt_pkg::op_e'(in_i.operation) == mgt_pkg::OpLoad) begin
            state_d = StLoadWb;
          end else begin
            state_d = StUpdStats;
          end
        end
      end
      StLoadWb: begin
        state_d = StIdle;
      end
      StUpdStats: begin
        if (deterministic_q) begin
          col_d   = stats_rd.max_column;
          state_d = StFinish;
        end else if (mod_start) begin
          state_d = StDiv;
        end else begin
          rem_left_d = 12'd1;
          state_d    = StWalkStart;
        end
      end
      StDiv: begin
        if (mod_done) begin
          rem_left_d = mod_rem + 12'd1;
          state_d    = StWalkStart;
        end
      end
      StWalkStart: begin
        col_d   = '0;
        state_d = StWalk;
      end
      StWalk: begin
        if ((col_q < last_col) && (rem_left_q > {4'd0, tbl_rd})) begin
          rem_left_d = rem_left_q - {4'd0, tbl_rd};
          col_d      = col_q + 4'd1;
        end else begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          or_mask_d   = mgt_pkg::scatter_mask(col_q, output_nodes_q, n_out, NodeMask);
          chosen_d    = col_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      row_q       <= '0;
      col_q       <= '0;
      val_q       <= '0;
      draw_q      <= '0;
      rem_left_q  <= '0;
      out_valid_q <= 1'b0;
      or_mask_q   <= '0;
      chosen_q    <= '0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      val_q       <= val_d;
      draw_q      <= draw_d;
      rem_left_q  <= rem_left_d;
      out_valid_q <= out_valid_d;
      or_mask_q   <= or_mask_d;
      chosen_q    <= chosen_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.or_mask       = or_mask_q;
  assign out_o.chosen_column = chosen_q;

  mgt_table_ram u_table (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_addr_i (tbl_rd_addr),
    .rd_data_o (tbl_rd)
  );

  mgt_row_stats u_stats (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_row_i  (stats_rd_row),
    .wr_i      (stats_wr),
    .rd_data_o (stats_rd)
  );

  mgt_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (draw_q),
    .divisor_i  (stats_rd.sum - 12'd1),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

endmodule

/* rtl/mgt_table_ram.sv */
// Transition table memory: 256 bytes, one write and one registered read port.
`timescale 1ns / 1ps

module mgt_table_ram (
  input  logic                         clk_i,
  input  mgt_pkg::tbl_wr_t             wr_i,
  input  logic [mgt_pkg::AddrW-1:0]    rd_addr_i,
  output logic [mgt_pkg::ValW-1:0]     rd_data_o
);

  logic [mgt_pkg::ValW-1:0] mem [2**mgt_pkg::AddrW];
  logic [mgt_pkg::ValW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/mgt_row_stats.sv */
// Per-row running sum and argmax store, with valid bits standing in for a reset of zero.
`timescale 1ns / 1ps

module mgt_row_stats (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [mgt_pkg::RowW-1:0]   rd_row_i,
  input  mgt_pkg::stats_wr_t         wr_i,
  output mgt_pkg::row_stats_t        rd_data_o
);

  localparam int unsigned Rows = 2**mgt_pkg::RowW;

  mgt_pkg::row_stats_t mem [Rows];
  mgt_pkg::row_stats_t rd_data_q;
  logic [Rows-1:0]     valid_q;
  logic                rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.row] <= wr_i.data;
    end
    rd_data_q <= mem[rd_row_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.row] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_row_i];
    end
  end

  // A row never written reads as all zero.
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

/* rtl/mgt_mod_unit.sv */
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps

module mgt_mod_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mgt_pkg::DrawW-1:0]  dividend_i,
  input  logic [mgt_pkg::SumW-1:0]   divisor_i,
  output logic                       done_o,
  output logic [mgt_pkg::SumW-1:0]   rem_o
);

  localparam int unsigned StepW = $clog2(mgt_pkg::DrawW);
  localparam logic [StepW-1:0] StepLast = StepW'(mgt_pkg::DrawW - 1);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [StepW-1:0]          step_q, step_d;
  logic [mgt_pkg::DrawW-1:0] dvd_q, dvd_d;
  logic [mgt_pkg::SumW-1:0]  div_q, div_d;
  logic [mgt_pkg::SumW-1:0]  rem_q, rem_d;
  logic [mgt_pkg::SumW:0]    trial;

  // The remainder stays below the divisor, so the shifted trial value fits one extra bit.
  assign trial = {rem_q, dvd_q[mgt_pkg::DrawW-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[mgt_pkg::DrawW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = mgt_pkg::SumW'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[mgt_pkg::SumW-1:0];
      end
      if (step_q == StepLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/mgt_checker.sv */
// Port-level assertions for the Markov gate transition unit and their binding.
`timescale 1ns / 1ps

module mgt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [mgt_pkg::NodeW-1:0]  or_mask_i,
  input logic [mgt_pkg::ColW-1:0]   chosen_column_i
);

  // A pending result is held until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before its transaction completed");

  // One transaction at a time: the input closes right after acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while a transaction is in progress");

  // A new result only appears at the end of an update, when the input was closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without an update in progress");

  // Column zero sets no output node.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (chosen_column_i == '0) |-> (or_mask_i == '0))
    else $error("non-zero mask for column zero");

endmodule

bind markov_gate_transition_unit mgt_checker u_mgt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .or_mask_i       (out_o.or_mask),
  .chosen_column_i (out_o.chosen_column)
);
